// File: rtl/xtea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared constants, types and per-stage schedule for the XTEA pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned ROUNDS     = 32;
  localparam int unsigned STAGES     = 2 * ROUNDS;   // one half-round per stage
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned KEY_IDX_W  = $clog2(KEY_WORDS);
  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef word_t [KEY_WORDS-1:0] key_set_t;

  // configuration register indexes
  localparam key_idx_t KEY_A_IDX = 2'd0;
  localparam key_idx_t KEY_B_IDX = 2'd1;
  localparam key_idx_t KEY_C_IDX = 2'd2;
  localparam key_idx_t KEY_D_IDX = 2'd3;

  // op codes
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  // one pipeline beat
  typedef struct packed {
    logic  valid;
    logic  op;
    word_t w0;
    word_t w1;
  } beat_t;

  // constant schedule of one stage
  typedef struct packed {
    logic  half;
    word_t enc_sum;
    word_t dec_sum;
  } stage_cfg_t;

  function automatic stage_cfg_t stage_cfg(input int unsigned s);
    int unsigned  r;
    int unsigned  h;
    logic [63:0]  prod;
    stage_cfg_t   c;
    r = s >> 1;
    h = s & 1;
    c.half = h[0];
    prod = 64'(r + h) * 64'(DELTA);
    c.enc_sum = prod[WORD_W-1:0];
    prod = 64'(ROUNDS - r - h) * 64'(DELTA);
    c.dec_sum = prod[WORD_W-1:0];
    return c;
  endfunction

endpackage

// File: rtl/xtea_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_stage
// One registered XTEA half-round; direction and word roles follow op.
// ----------------------------------------------------------------------------
module xtea_stage import xtea_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stage_cfg_t cfg,
  input  key_set_t   key,
  input  beat_t      in_beat,
  output beat_t      out_beat
);

  beat_t    beat_r;
  beat_t    beat_nxt;
  logic     src_is_w0;
  word_t    src;
  word_t    tgt;
  word_t    sum;
  key_idx_t sel;
  word_t    key_add;
  word_t    mix;
  word_t    f;
  word_t    upd;

  always_comb begin
    // encrypt: half 0 updates w0 from w1; decrypt: half 0 updates w1 from w0
    src_is_w0 = in_beat.op ^ cfg.half;
    src       = src_is_w0 ? in_beat.w0 : in_beat.w1;
    tgt       = src_is_w0 ? in_beat.w1 : in_beat.w0;
    sum       = (in_beat.op == OP_DEC) ? cfg.dec_sum : cfg.enc_sum;
    sel       = (in_beat.op == cfg.half) ? sum[1:0] : sum[12:11];
    key_add   = sum + key[sel];
    mix       = ((src << 4) ^ (src >> 5)) + src;
    f         = mix ^ key_add;
    upd       = (in_beat.op == OP_DEC) ? (tgt - f) : (tgt + f);

    beat_nxt  = in_beat;
    if (src_is_w0) begin
      beat_nxt.w1 = upd;
    end else begin
      beat_nxt.w0 = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= in_beat.valid;
    end
    if (in_beat.valid) begin
      beat_r.op <= beat_nxt.op;
      beat_r.w0 <= beat_nxt.w0;
      beat_r.w1 <= beat_nxt.w1;
    end
  end

  assign out_beat = beat_r;

endmodule

// File: rtl/xtea_block_cipher.sv
`timescale 1ns / 1ps
// The result beat leaves the last stage register together with out_valid.
// Throughput: one block per cycle while busy is low, one half-round per stage.
// Reset (synchronous, rst_n low): key words clear to 0, all stage valid bits clear,
// busy is high through reset and is cleared by the first clock edge that samples rst_n high. Results cannot be stalled.
// ----------------------------------------------------------------------------
// xtea_block_cipher
// Fully unrolled XTEA encrypt/decrypt pipeline with a 128-bit configured key.
// ----------------------------------------------------------------------------
module xtea_block_cipher import xtea_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  // command channel
  input  logic     start,
  output logic     busy,
  input  logic     in_op,
  input  word_t    in_block_first,
  input  word_t    in_block_second,
  // result channel
  output logic     out_valid,
  output word_t    out_first,
  output word_t    out_second,
  // configuration
  input  logic     cfg_we,
  input  key_idx_t cfg_index,
  input  word_t    cfg_wdata
);

  key_set_t key_r;
  logic     busy_r;
  beat_t    pipe [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          KEY_A_IDX: key_r[KEY_A_IDX] <= cfg_wdata;
          KEY_B_IDX: key_r[KEY_B_IDX] <= cfg_wdata;
          KEY_C_IDX: key_r[KEY_C_IDX] <= cfg_wdata;
          KEY_D_IDX: key_r[KEY_D_IDX] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // entry beat: valid, op, first half, second half
  assign pipe[0] = {start & ~busy_r, in_op, in_block_first, in_block_second};

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam stage_cfg_t CFG = stage_cfg(s);
    xtea_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (CFG),
      .key      (key_r),
      .in_beat  (pipe[s]),
      .out_beat (pipe[s+1])
    );
  end

  assign out_valid  = pipe[STAGES].valid;
  assign out_first  = pipe[STAGES].w0;
  assign out_second = pipe[STAGES].w1;

  // every result beat traces back to a valid beat in the first stage register
  a_out_from_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(pipe[1].valid, STAGES - 1))
    else $error("result beat without matching entry");

  // direction bit stays aligned with its block across the whole pipeline
  a_op_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pipe[STAGES].op == $past(in_op, STAGES)))
    else $error("op misaligned at pipeline exit");

  // pipeline is empty while busy after reset
  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result beat while busy after reset");

endmodule

// File: tb/xtea_block_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_cipher_tb
// Checks the XTEA pipeline against its own XTEA encrypt/decrypt predictor
// under several key settings, with directed edge blocks, round trips and
// random blocks fed through a start/busy driver with random gaps.
// ----------------------------------------------------------------------------
module xtea_block_cipher_tb;
  import xtea_pkg::*;

  localparam int unsigned LATENCY     = STAGES + 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 210;

  typedef struct {
    logic  op;
    word_t first;
    word_t second;
  } block_in_t;

  typedef struct {
    word_t first;
    word_t second;
  } block_out_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  logic     in_op = OP_ENC;
  word_t    in_block_first = '0;
  word_t    in_block_second = '0;
  logic     out_valid;
  word_t    out_first;
  word_t    out_second;
  logic     cfg_we = 1'b0;
  key_idx_t cfg_index = KEY_A_IDX;
  word_t    cfg_wdata = '0;

  block_in_t   pending_blocks[$];
  block_out_t  expected_blocks[$];
  key_set_t    key_now = '0;
  logic        beat_taken = 1'b0;
  logic        steady = 1'b0;
  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  xtea_block_cipher i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_block_first  (in_block_first),
    .in_block_second (in_block_second),
    .out_valid       (out_valid),
    .out_first       (out_first),
    .out_second      (out_second),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic word_t mix_word(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // full XTEA (ROUNDS iterations) on one block with the key currently loaded
  function automatic block_out_t xtea_crypt(input logic op, input word_t a, input word_t b);
    word_t      sum;
    word_t      v0;
    word_t      v1;
    block_out_t res;
    v0 = a;
    v1 = b;
    if (op == OP_ENC) begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        v0 += mix_word(v1) ^ (sum + key_now[sum[1:0]]);
        sum += DELTA;
        v1 += mix_word(v0) ^ (sum + key_now[sum[12:11]]);
      end
    end else begin
      sum = DELTA * ROUNDS;
      for (int r = 0; r < ROUNDS; r++) begin
        v1 -= mix_word(v0) ^ (sum + key_now[sum[12:11]]);
        sum -= DELTA;
        v0 -= mix_word(v1) ^ (sum + key_now[sum[1:0]]);
      end
    end
    res.first  = v0;
    res.second = v1;
    return res;
  endfunction

  task automatic push_block(input logic op, input word_t a, input word_t b);
    block_in_t item;
    item.op     = op;
    item.first  = a;
    item.second = b;
    pending_blocks.push_back(item);
    issued_count++;
  endtask

  // plaintext followed by the decryption of its predicted ciphertext
  task automatic push_round_trip(input word_t a, input word_t b);
    block_out_t ct;
    ct = xtea_crypt(OP_ENC, a, b);
    push_block(OP_ENC, a, b);
    push_block(OP_DEC, ct.first, ct.second);
  endtask

  function automatic word_t edge_word();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random_block();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      push_round_trip($urandom, $urandom);
    end else if (pick < 35) begin
      push_block(logic'($urandom_range(1)), edge_word(), edge_word());
    end else begin
      push_block(logic'($urandom_range(1)), $urandom, $urandom);
    end
  endtask

  task automatic write_word(input key_idx_t idx, input word_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_keys(input key_set_t k);
    write_word(KEY_A_IDX, k[KEY_A_IDX]);
    write_word(KEY_B_IDX, k[KEY_B_IDX]);
    write_word(KEY_C_IDX, k[KEY_C_IDX]);
    write_word(KEY_D_IDX, k[KEY_D_IDX]);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom;
    @(negedge clk);
  endtask

  // all beats accepted and answered, then let the pipe flush
  task automatic drain();
    while (accepted_count != issued_count || expected_blocks.size() != 0) @(negedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // driver: a beat stays on the ports until taken
  always @(negedge clk) begin : drive_blk
    block_in_t item;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (pending_blocks.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
        item = pending_blocks.pop_front();
        start           <= 1'b1;
        in_op           <= item.op;
        in_block_first  <= item.first;
        in_block_second <= item.second;
      end else begin
        start           <= 1'b0;
        in_op           <= logic'($urandom_range(1));
        in_block_first  <= $urandom;
        in_block_second <= $urandom;
      end
    end
  end

  // monitor: key shadow, acceptance and result check
  always @(posedge clk) begin : watch_blk
    block_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("xtea_block_cipher_tb NOT OK");
      $finish;
    end else begin
      beat_taken = 1'b0;
      if (rst_n) begin
        if (out_valid) begin
          if (expected_blocks.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("unexpected result %h %h", out_first, out_second);
          end else begin
            want = expected_blocks.pop_front();
            if (out_first !== want.first || out_second !== want.second) begin
              fail_count++;
              if (fail_count <= 10)
                $display("mismatch: expected %h %h, got %h %h",
                         want.first, want.second, out_first, out_second);
            end
          end
        end
        if (start && !busy) begin
          expected_blocks.push_back(xtea_crypt(in_op, in_block_first, in_block_second));
          accepted_count++;
          beat_taken = 1'b1;
        end
        if (cfg_we)
          key_now[cfg_index] = cfg_wdata;
      end
    end
  end

  initial begin : stim_blk
    key_set_t k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset key of all zeros
    push_block(OP_ENC, '0, '0);
    push_block(OP_DEC, '0, '0);
    push_block(OP_ENC, '1, '1);
    push_block(OP_DEC, '1, '1);
    push_block(OP_ENC, '0, '1);
    push_block(OP_DEC, '1, '0);
    push_block(OP_ENC, 32'h8000_0000, 32'h0000_0001);
    push_block(OP_DEC, 32'h5555_5555, 32'haaaa_aaaa);
    push_round_trip(32'h0123_4567, 32'h89ab_cdef);
    drain();

    // directed, all-ones key
    load_keys('1);
    push_block(OP_ENC, '0, '0);
    push_block(OP_DEC, '1, '1);
    push_block(OP_ENC, 32'haaaa_aaaa, 32'h5555_5555);
    push_round_trip('1, '0);
    push_round_trip(32'h4142_4344, 32'h4546_4748);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: k = '1;
        1: k = {32'h0000_0001, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000};
        2: k = '0;
        default: k = {$urandom, $urandom, $urandom, $urandom};
      endcase
      load_keys(k);
      steady = (p == 3);
      while (issued_count < 25 + (p + 1) * PHASE_ITEMS) push_random_block();
      drain();
    end

    if (fail_count == 0 && expected_blocks.size() == 0) begin
      $display("xtea_block_cipher_tb OK");
    end else begin
      $display("xtea_block_cipher_tb NOT OK");
    end
    $finish;
  end

endmodule
